[src/rau_pkg.sv]
`timescale 1ns / 1ps
package rau_pkg;
	localparam int OperandWidth = 32;
	localparam int MagWidth = 64;
	localparam int CntWidth = 7;

	localparam logic [2:0] MODE_ADD = 3'd0;
	localparam logic [2:0] MODE_SUB = 3'd1;
	localparam logic [2:0] MODE_MUL = 3'd2;
	localparam logic [2:0] MODE_DIV = 3'd3;
	localparam logic [2:0] MODE_CMP = 3'd4;
	localparam logic [2:0] MODE_RED = 3'd5;
	localparam logic [2:0] MODE_NEG = 3'd6;
	localparam logic [2:0] MODE_NOP = 3'd7;

	localparam logic [1:0] ORD_LT = 2'd0;
	localparam logic [1:0] ORD_EQ = 2'd1;
	localparam logic [1:0] ORD_GT = 2'd2;

	typedef enum logic [2:0] {
		DIV_NONE = 3'd0,
		DIV_GCD = 3'd1,
		DIV_NUM = 3'd2,
		DIV_DEN = 3'd3
	} div_sel_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic form;
		logic div_start;
		div_sel_t div_sel;
		logic out_load;
	} rau_cmd_t;

	typedef struct packed {
		logic div_done;
		logic gcd_done;
		logic short_path;
	} rau_stat_t;
endpackage

[src/rational_arithmetic_unit.sv]
`timescale 1ns / 1ps
// steps: load, prep, form; the short path then goes to output, else gcd, then the num and den quotients
// euclid steps each run a restoring divider
// throughput: one word at a time, next word accepted after the result is registered
// output register lets the result wait while the next word is taken
// arst_n clears the controller and output valid; payload registers are not reset
module rational_arithmetic_unit import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [135:0] s_tdata, // mode, a_num, a_den, b_num, b_den
	output logic m_tvalid,
	input logic m_tready,
	output logic [135:0] m_tdata // res_num, res_den, order, zero_den
);
	rau_cmd_t cmd;
	rau_stat_t stat;
	logic in_ready, out_set, valid_q;

	assign s_tready = in_ready;
	assign m_tvalid = valid_q;

	rau_ctrl u_ctrl (
		.clk, .arst_n,
		.in_fire(s_tvalid && in_ready),
		.out_free(!valid_q || m_tready),
		.stat, .cmd, .in_ready, .out_set
	);

	rau_datapath u_dp (
		.clk, .arst_n, .cmd, .stat,
		.in_word(s_tdata), .out_word(m_tdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (out_set) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end
endmodule

[src/rau_datapath.sv]
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input rau_cmd_t cmd,
	output rau_stat_t stat,
	input logic [135:0] in_word,
	output logic [135:0] out_word
);
	logic [2:0] mode_q;
	logic [OperandWidth-1:0] an_q, ad_q, bn_q, bd_q;
	logic an_neg_q, ad_neg_q, bn_neg_q, bd_neg_q;
	logic [MagWidth-1:0] p0_q, p1_q, p2_q;
	logic p0_neg_q, p1_neg_q, p2_neg_q;
	logic [MagWidth-1:0] num_q, den_q;
	logic num_neg_q, den_neg_q;
	logic short_q;
	logic [63:0] s_num_q;
	logic [62:0] s_den_q;
	logic [1:0] s_ord_q;
	logic s_zd_q;
	logic [MagWidth-1:0] g_q, nq_q;
	logic [MagWidth-1:0] rem_q, quo_q, dvs_q, dvd_q;
	logic [CntWidth-1:0] cnt_q;
	logic busy_q, done_q;
	logic [MagWidth-1:0] gb_q;
	logic gcd_mode_q;
	logic [63:0] o_num_q;
	logic [62:0] o_den_q;
	logic [1:0] o_ord_q;
	logic o_zd_q;

	function automatic logic [OperandWidth:0] to_sm(input logic [31:0] v);
		logic [OperandWidth-1:0] x, m;
		logic n;
		x = v[OperandWidth-1:0];
		n = x[OperandWidth-1];
		m = n ? (~x + 1'b1) : x;
		if (m == '0) n = 1'b0;
		return {n, m};
	endfunction

	logic [OperandWidth:0] an_sm, ad_sm, bn_sm, bd_sm;
	assign an_sm = to_sm(in_word[34:3]);
	assign ad_sm = to_sm(in_word[66:35]);
	assign bn_sm = to_sm(in_word[98:67]);
	assign bd_sm = to_sm(in_word[130:99]);

	logic [MagWidth-1:0] sum_mag;
	logic sum_neg;
	always_comb begin
		if (p0_neg_q == p1_neg_q) begin
			sum_mag = p0_q + p1_q;
			sum_neg = p0_neg_q;
		end else if (p0_q >= p1_q) begin
			sum_mag = p0_q - p1_q;
			sum_neg = p0_neg_q;
		end else begin
			sum_mag = p1_q - p0_q;
			sum_neg = p1_neg_q;
		end
		if (sum_mag == '0) sum_neg = 1'b0;
	end

	logic [1:0] cmp_ord;
	logic [1:0] cmp_raw;
	always_comb begin
		if (p0_neg_q != p1_neg_q) cmp_raw = p0_neg_q ? ORD_LT : ORD_GT;
		else if (p0_q == p1_q) cmp_raw = ORD_EQ;
		else if (p0_neg_q) cmp_raw = (p0_q > p1_q) ? ORD_LT : ORD_GT;
		else cmp_raw = (p0_q > p1_q) ? ORD_GT : ORD_LT;
		cmp_ord = cmp_raw;
		if (ad_neg_q != bd_neg_q) begin
			if (cmp_raw == ORD_LT) cmp_ord = ORD_GT;
			else if (cmp_raw == ORD_GT) cmp_ord = ORD_LT;
		end
	end

	logic [MagWidth-1:0] f_num, f_den;
	logic f_num_neg, f_den_neg, f_zd, f_short;
	logic [1:0] f_ord;
	always_comb begin
		f_num = num_q;
		f_num_neg = num_neg_q;
		f_den = den_q;
		f_den_neg = den_neg_q;
		f_ord = ORD_LT;
		f_zd = 1'b0;
		f_short = 1'b1;
		if (mode_q != MODE_NOP) begin
			if (mode_q <= MODE_CMP && (ad_q == '0 || bd_q == '0)) begin
				f_zd = 1'b1;
				if (mode_q == MODE_CMP) f_ord = ORD_EQ;
			end else begin
				case (mode_q)
					MODE_ADD, MODE_SUB: begin
						f_num = sum_mag; f_num_neg = sum_neg;
						f_den = p2_q; f_den_neg = p2_neg_q;
						f_short = (sum_mag == '0);
					end
					MODE_MUL: begin
						f_num = p1_q; f_num_neg = p1_neg_q;
						f_den = p2_q; f_den_neg = p2_neg_q;
						f_short = (p1_q == '0);
					end
					MODE_DIV: begin
						f_num = p0_q; f_num_neg = p0_neg_q;
						f_den = p1_q; f_den_neg = p1_neg_q;
						f_zd = (p1_q == '0);
						f_short = (p1_q == '0) || (p0_q == '0);
					end
					MODE_CMP: f_ord = cmp_ord;
					MODE_RED, MODE_NEG: begin
						f_num = MagWidth'(an_q);
						f_num_neg = (mode_q == MODE_NEG) ? (an_q != '0 && !an_neg_q) :
							an_neg_q;
						f_den = MagWidth'(ad_q); f_den_neg = ad_neg_q;
						f_zd = (ad_q == '0);
						f_short = (ad_q == '0) || (an_q == '0);
					end
					default: f_short = 1'b1;
				endcase
			end
		end
	end

	logic [MagWidth:0] trial;
	logic [MagWidth-1:0] rem_sh, rem_nx;
	logic div_last, gcd_more;
	assign rem_sh = {rem_q[MagWidth-2:0], dvd_q[MagWidth-1]};
	assign trial = {rem_q, dvd_q[MagWidth-1]} - {1'b0, dvs_q};
	assign rem_nx = trial[MagWidth] ? rem_sh : trial[MagWidth-1:0];
	assign div_last = busy_q && (cnt_q == CntWidth'(MagWidth - 1));
	assign gcd_more = div_last && gcd_mode_q && (rem_nx != '0);

	logic [MagWidth-1:0] sat_n, sat_d;
	assign sat_n = nq_q[63] ? 64'h7FFFFFFFFFFFFFFF : nq_q;
	assign sat_d = quo_q[63] ? 64'h7FFFFFFFFFFFFFFF : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_word[2:0];
			{an_neg_q, an_q} <= an_sm;
			{ad_neg_q, ad_q} <= ad_sm;
			{bn_neg_q, bn_q} <= bn_sm;
			{bd_neg_q, bd_q} <= bd_sm;
		end
		if (cmd.prep) begin
			p0_q <= MagWidth'(an_q) * MagWidth'(bd_q);
			p0_neg_q <= (an_q != '0 && bd_q != '0) && (an_neg_q != bd_neg_q);
			p1_q <= MagWidth'((mode_q == MODE_MUL) ? an_q : ad_q) * MagWidth'(bn_q);
			p1_neg_q <= (mode_q == MODE_MUL) ?
				((an_q != '0 && bn_q != '0) && (an_neg_q != bn_neg_q)) :
				((ad_q != '0 && bn_q != '0) &&
				(ad_neg_q != (bn_neg_q ^ (mode_q == MODE_SUB && bn_q != '0))));
			p2_q <= MagWidth'(ad_q) * MagWidth'(bd_q);
			p2_neg_q <= (ad_q != '0 && bd_q != '0) && (ad_neg_q != bd_neg_q);
		end
		if (cmd.form) begin
			s_num_q <= '0;
			s_den_q <= 63'd1;
			s_ord_q <= f_ord;
			s_zd_q <= f_zd;
			short_q <= f_short;
			num_q <= f_num;
			num_neg_q <= f_num_neg;
			den_q <= f_den;
			den_neg_q <= f_den_neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= cmd.div_start || (busy_q && (!div_last || gcd_more));
			done_q <= div_last && !gcd_more;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			gcd_mode_q <= (cmd.div_sel == DIV_GCD);
			case (cmd.div_sel)
				DIV_GCD: begin
					dvd_q <= num_q; dvs_q <= den_q;
					gb_q <= den_q;
				end
				DIV_NUM: begin dvd_q <= num_q; dvs_q <= g_q; end
				DIV_DEN: begin dvd_q <= den_q; dvs_q <= g_q; end
				default: begin dvd_q <= num_q; dvs_q <= den_q; end
			endcase
		end else if (gcd_more) begin
			gb_q <= rem_nx;
			dvd_q <= gb_q;
			dvs_q <= rem_nx;
			rem_q <= '0;
			cnt_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[MagWidth-2:0], 1'b0};
			quo_q <= {quo_q[MagWidth-2:0], !trial[MagWidth]};
			rem_q <= rem_nx;
			cnt_q <= cnt_q + 1'b1;
			if (div_last && gcd_mode_q) g_q <= gb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (done_q && cmd.div_sel == DIV_NUM) nq_q <= quo_q;
	end

	assign stat.div_done = done_q;
	assign stat.gcd_done = done_q;
	assign stat.short_path = short_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (short_q) begin
				o_num_q <= s_num_q; o_den_q <= s_den_q;
				o_ord_q <= s_ord_q; o_zd_q <= s_zd_q;
			end else begin
				o_num_q <= (num_neg_q != den_neg_q) ? (~sat_n + 1'b1) : sat_n;
				o_den_q <= sat_d[62:0];
				o_ord_q <= ORD_LT;
				o_zd_q <= 1'b0;
			end
		end
	end

	assign out_word = {6'd0, o_zd_q, o_ord_q, o_den_q, o_num_q};
endmodule

[src/rau_ctrl.sv]
`timescale 1ns / 1ps
module rau_ctrl import rau_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_free,
	input rau_stat_t stat,
	output rau_cmd_t cmd,
	output logic in_ready,
	output logic out_set
);
	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_PREP = 8'b00000010,
		S_FORM = 8'b00000100,
		S_GCD = 8'b00001000,
		S_DNUM = 8'b00010000,
		S_DDEN = 8'b00100000,
		S_OUT = 8'b01000000,
		S_WAIT = 8'b10000000
	} state_t;

	state_t state_q, state_d;
	logic started_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.div_sel = DIV_NONE;
		out_set = 1'b0;
		in_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: if (in_fire) begin
				cmd.load = 1'b1;
				state_d = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d = S_FORM;
			end
			S_FORM: begin
				cmd.form = 1'b1;
				state_d = S_GCD;
			end
			S_GCD: begin
				cmd.div_sel = DIV_GCD;
				if (stat.short_path) state_d = S_OUT;
				else if (!started_q) cmd.div_start = 1'b1;
				else if (stat.div_done) state_d = S_DNUM;
			end
			S_DNUM: begin
				cmd.div_sel = DIV_NUM;
				if (!started_q) cmd.div_start = 1'b1;
				else if (stat.div_done) state_d = S_DDEN;
			end
			S_DDEN: begin
				cmd.div_sel = DIV_DEN;
				if (!started_q) cmd.div_start = 1'b1;
				else if (stat.div_done) state_d = S_OUT;
			end
			S_OUT: if (out_free) begin
				cmd.out_load = 1'b1;
				out_set = 1'b1;
				state_d = S_IDLE;
			end
			S_WAIT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) started_q <= 1'b0;
			else if (cmd.div_start) started_q <= 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_start_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !cmd.div_start) else $error("double start");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE) else $error("load outside idle");
	a_out_path: assert property (@(posedge clk) disable iff (!arst_n)
		out_set |=> state_q == S_IDLE) else $error("bad exit");
`endif
endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import rau_pkg::*;

	localparam int N_RANDOM = 1580;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [2:0] mode;
		logic [31:0] an;
		logic [31:0] ad;
		logic [31:0] bn;
		logic [31:0] bd;
	} frac_op_t;

	typedef struct packed {
		logic [63:0] num;
		logic [62:0] den;
		logic [1:0] ord;
		logic zd;
	} frac_res_t;

	typedef struct {
		frac_op_t op;
		bit known;
		frac_res_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [135:0] s_tdata = '0; // mode, a_num, a_den, b_num, b_den
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [135:0] m_tdata; // res_num, res_den, order, zero_den

	frac_res_t pending_q[$];
	int mismatches = 0;
	int phase = 0;
	bit hold_rx = 1'b0;

	rational_arithmetic_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void to_sign_mag(input logic [31:0] v, output bit s,
			output logic [63:0] m);
		s = v[31];
		m = s ? {32'b0, -v} : {32'b0, v};
		if (m == 0) s = 1'b0;
	endfunction

	function automatic void mul_sm(input bit xs, input logic [63:0] xm, input bit ys,
			input logic [63:0] ym, output bit rs, output logic [63:0] rm);
		rm = xm * ym;
		rs = (rm != 0) && (xs != ys);
	endfunction

	function automatic frac_res_t reduce_frac(input bit ns, input logic [63:0] nm,
			input bit ds, input logic [63:0] dm);
		frac_res_t r;
		logic [63:0] g, d, t;
		r = '{num: 64'd0, den: 63'd1, ord: ORD_LT, zd: 1'b0};
		if (dm == 0) begin
			r.zd = 1'b1;
			return r;
		end
		if (nm == 0) return r;
		g = nm;
		d = dm;
		while (d != 0) begin
			t = g % d;
			g = d;
			d = t;
		end
		nm = nm / g;
		dm = dm / g;
		if (nm > 64'h7FFF_FFFF_FFFF_FFFF) nm = 64'h7FFF_FFFF_FFFF_FFFF;
		if (dm > 64'h7FFF_FFFF_FFFF_FFFF) dm = 64'h7FFF_FFFF_FFFF_FFFF;
		r.num = (ns != ds) ? -nm : nm;
		r.den = dm[62:0];
		return r;
	endfunction

	function automatic frac_res_t predict_frac(input frac_op_t op);
		frac_res_t r;
		bit ans, ads, bns, bds, ps, qs, ss;
		logic [63:0] anm, adm, bnm, bdm, pm, qm, sm;
		r = '{num: 64'd0, den: 63'd1, ord: ORD_LT, zd: 1'b0};
		to_sign_mag(op.an, ans, anm);
		to_sign_mag(op.ad, ads, adm);
		to_sign_mag(op.bn, bns, bnm);
		to_sign_mag(op.bd, bds, bdm);
		if (op.mode == MODE_NOP) return r;
		if (op.mode <= MODE_CMP && (adm == 0 || bdm == 0)) begin
			r.zd = 1'b1;
			if (op.mode == MODE_CMP) r.ord = ORD_EQ;
			return r;
		end
		case (op.mode)
			MODE_ADD, MODE_SUB: begin
				if (op.mode == MODE_SUB && bnm != 0) bns = !bns;
				mul_sm(ans, anm, bds, bdm, ps, pm);
				mul_sm(ads, adm, bns, bnm, qs, qm);
				if (ps == qs) begin
					sm = pm + qm;
					ss = ps;
				end else if (pm >= qm) begin
					sm = pm - qm;
					ss = ps;
				end else begin
					sm = qm - pm;
					ss = qs;
				end
				if (sm == 0) ss = 1'b0;
				mul_sm(ads, adm, bds, bdm, qs, qm);
				r = reduce_frac(ss, sm, qs, qm);
			end
			MODE_MUL: begin
				mul_sm(ans, anm, bns, bnm, ps, pm);
				mul_sm(ads, adm, bds, bdm, qs, qm);
				r = reduce_frac(ps, pm, qs, qm);
			end
			MODE_DIV: begin
				mul_sm(ans, anm, bds, bdm, ps, pm);
				mul_sm(ads, adm, bns, bnm, qs, qm);
				r = reduce_frac(ps, pm, qs, qm);
			end
			MODE_CMP: begin
				int c;
				mul_sm(ans, anm, bds, bdm, ps, pm);
				mul_sm(ads, adm, bns, bnm, qs, qm);
				if (ps != qs) c = ps ? -1 : 1;
				else if (pm == qm) c = 0;
				else if (ps) c = (pm > qm) ? -1 : 1;
				else c = (pm > qm) ? 1 : -1;
				if (ads != bds) c = -c;
				r.ord = (c < 0) ? ORD_LT : (c == 0) ? ORD_EQ : ORD_GT;
			end
			MODE_RED: r = reduce_frac(ans, anm, ads, adm);
			default: begin
				if (anm != 0) ans = !ans;
				r = reduce_frac(ans, anm, ads, adm);
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		int pick;
		logic [31:0] edges[6] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001,
			32'hFFFF_FFFF, 32'd1, 32'd0};
		pick = $urandom_range(99);
		if (pick < 70) return 32'($signed($urandom_range(40)) - 20);
		if (pick < 90) return $urandom;
		return edges[$urandom_range(5)];
	endfunction

	function automatic frac_op_t rand_op();
		frac_op_t op;
		op.mode = ($urandom_range(99) < 3) ? MODE_NOP : 3'($urandom_range(6));
		op.an = rand_operand();
		op.ad = rand_operand();
		op.bn = rand_operand();
		op.bd = rand_operand();
		return op;
	endfunction

	task automatic send_word(input frac_op_t op, input bit known, input frac_res_t res);
		int idle_pct;
		idle_pct = (phase == 0) ? 18 : (phase == 1) ? 69 : 0;
		if (s_tvalid && $urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, op.bd, op.bn, op.ad, op.an, op.mode};
		do @(posedge clk); while (!s_tready);
		pending_q.push_back(known ? res : predict_frac(op));
	endtask

	initial begin
		stim_row_t rows[$];
		frac_res_t none;
		none = '{num: 64'd0, den: 63'd1, ord: ORD_LT, zd: 1'b0};
		rows = '{
			'{'{MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b0, none},
			'{'{MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd3}, 1'b0, none},
			'{'{MODE_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9}, 1'b0, none},
			'{'{MODE_DIV, 32'd5, 32'd6, -32'sd10, 32'd3}, 1'b0, none},
			'{'{MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd3}, 1'b1,
				'{64'd0, 63'd1, ORD_LT, 1'b1}},
			'{'{MODE_CMP, 32'd1, 32'd2, 32'd1, 32'd0}, 1'b1,
				'{64'd0, 63'd1, ORD_EQ, 1'b1}},
			'{'{MODE_DIV, 32'd1, 32'd2, 32'd0, 32'd5}, 1'b1,
				'{64'd0, 63'd1, ORD_LT, 1'b1}},
			'{'{MODE_RED, 32'd0, 32'd5, 32'd7, 32'd7}, 1'b1,
				'{64'd0, 63'd1, ORD_LT, 1'b0}},
			'{'{MODE_RED, 32'd4, 32'd6, 32'd9, 32'd0}, 1'b1,
				'{64'd2, 63'd3, ORD_LT, 1'b0}},
			'{'{MODE_NEG, 32'd3, -32'sd4, 32'd1, 32'd1}, 1'b1,
				'{64'd3, 63'd4, ORD_LT, 1'b0}},
			'{'{MODE_RED, 32'd3, 32'd0, 32'd1, 32'd1}, 1'b1,
				'{64'd0, 63'd1, ORD_LT, 1'b1}},
			'{'{MODE_NOP, 32'd3, 32'd4, 32'd5, 32'd6}, 1'b1,
				'{64'd0, 63'd1, ORD_LT, 1'b0}},
			'{'{MODE_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1}, 1'b1,
				'{64'h4000_0000_0000_0000, 63'd1, ORD_LT, 1'b0}},
			'{'{MODE_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1}, 1'b0, none},
			'{'{MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
				32'h8000_0000}, 1'b0, none},
			'{'{MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
				32'h8000_0000}, 1'b0, none},
			'{'{MODE_DIV, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000,
				32'h7FFF_FFFF}, 1'b0, none},
			'{'{MODE_CMP, 32'd1, 32'd2, 32'd2, 32'd3}, 1'b0, none},
			'{'{MODE_CMP, 32'd2, 32'd4, 32'd1, 32'd2}, 1'b0, none},
			'{'{MODE_CMP, 32'd1, -32'sd2, 32'd2, 32'd3}, 1'b0, none},
			'{'{MODE_CMP, 32'd5, -32'sd2, -32'sd1, -32'sd3}, 1'b0, none},
			'{'{MODE_NEG, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0}, 1'b0, none},
			'{'{MODE_NEG, 32'd0, -32'sd7, 32'd0, 32'd0}, 1'b0, none}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_word(rows[i].op, rows[i].known, rows[i].res);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 3) phase = 1;
			if (i == 2 * N_RANDOM / 3) begin
				s_tvalid <= 1'b0;
				wait (pending_q.size() == 0);
				@(posedge clk);
				phase = 2;
				hold_rx = 1'b1;
			end
			send_word(rand_op(), 1'b0, none);
		end
		s_tvalid <= 1'b0;
		wait (pending_q.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS rational_arithmetic_unit");
		end else begin
			$display("FAIL rational_arithmetic_unit");
		end
		$finish;
	end

	// receiver side: random stall, one long hold-off at the start of the last phase
	initial begin
		frac_res_t exp_r, got;
		int idle_pct;
		int held;
		held = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got.num = m_tdata[63:0];
				got.den = m_tdata[126:64];
				got.ord = m_tdata[128:127];
				got.zd = m_tdata[129];
				if (pending_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected word %h", m_tdata);
				end else begin
					exp_r = pending_q.pop_front();
					if (got != exp_r) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch exp %0d/%0d ord %0d zd %0d got %0d/%0d ord %0d zd %0d",
								$signed(exp_r.num), exp_r.den, exp_r.ord, exp_r.zd,
								$signed(got.num), got.den, got.ord, got.zd);
					end
				end
			end
			idle_pct = (phase == 0) ? 69 : (phase == 1) ? 18 : 0;
			if (hold_rx && held < LONG_HOLD) begin
				held++;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		#1_000_000_000;
		$display("FAIL rational_arithmetic_unit");
		$finish;
	end
endmodule

[rational_arithmetic_unit.f]
src/rau_pkg.sv
src/rau_datapath.sv
src/rau_ctrl.sv
src/rational_arithmetic_unit.sv
dv/testbench.sv
